@@ rtl/vbq_pkg.sv @@
// Shared constants, types and opcodes for the vertex box quantizer.
// No dependencies.
package vbq_pkg;
    localparam int MAX_FEATURES = 1024;
    localparam int FEAT_BITS    = 10;
    localparam int COORD_BITS   = 32;
    localparam int CFG_IDX_BITS = 3;

    localparam logic [1:0] OP_BEGIN   = 2'd0;
    localparam logic [1:0] OP_LOAD    = 2'd1;
    localparam logic [1:0] OP_MEASURE = 2'd2;
    localparam logic [1:0] OP_EMIT    = 2'd3;

    localparam logic [CFG_IDX_BITS-1:0] REG_MIN_E = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_MIN_N = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_MIN_U = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_MAX_E = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_MAX_N = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] REG_MAX_U = 3'd5;
    localparam logic [CFG_IDX_BITS-1:0] REG_COUNT = 3'd6;
    localparam logic [CFG_IDX_BITS-1:0] REG_USEID = 3'd7;

    localparam logic [COORD_BITS-1:0] COORD_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};

    // Divider operands: numerator 2*d*65535+span (<2^50), denominator 2*span (<2^34).
    localparam int NUM_BITS = 50;
    localparam int DEN_BITS = 34;

    typedef struct packed {
        logic                  start;
        logic [NUM_BITS-1:0]   num;
        logic [DEN_BITS-1:0]   den;
    } div_req_t;

    typedef struct packed {
        logic                  done;
        logic [15:0]           quo;
    } div_rsp_t;
endpackage

@@ rtl/vbq_divider.sv @@
// Restoring radix-2 divider, one quotient bit per cycle, 16-bit quotient.
// Depends on vbq_pkg. Caller guarantees quotient < 2^16.
module vbq_divider (
    input  logic              aclk,
    input  logic              aresetn,
    input  vbq_pkg::div_req_t req,
    output vbq_pkg::div_rsp_t rsp
);
    logic [vbq_pkg::NUM_BITS-1:0] rem_reg, rem_next;
    logic [vbq_pkg::DEN_BITS-1:0] den_reg;
    logic [15:0]                  quo_reg, quo_next;
    logic [4:0]                   cnt_reg, cnt_next;
    logic                         busy_reg, busy_next, done_reg, done_next;
    logic [vbq_pkg::NUM_BITS-1:0] trial;

    always_comb begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {{(vbq_pkg::NUM_BITS-vbq_pkg::DEN_BITS){1'b0}}, den_reg} << cnt_reg;
        if (req.start) begin
            rem_next  = req.num;
            quo_next  = '0;
            cnt_next  = 5'd15;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (rem_reg >= trial) begin
                rem_next = rem_reg - trial;
                quo_next = quo_reg | (16'd1 << cnt_reg[3:0]);
            end
            if (cnt_reg == 5'd0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end else begin
                cnt_next = cnt_reg - 5'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        cnt_reg <= cnt_next;
        if (req.start) den_reg <= req.den;
    end

    assign rsp.done = done_reg;
    assign rsp.quo  = quo_reg;
endmodule

@@ rtl/vbq_tables.sv @@
// Feature tables: lowest-up memory and info memory, each one synchronous RAM.
// Depends on vbq_pkg. Both memories return read data in the cycle after the address.
module vbq_tables (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           clear_all,
    input  logic [vbq_pkg::FEAT_BITS-1:0]  rd_addr,
    input  logic                           low_we,
    input  logic [vbq_pkg::FEAT_BITS-1:0]  low_waddr,
    input  logic [vbq_pkg::COORD_BITS-1:0] low_wdata,
    input  logic                           info_we,
    input  logic [vbq_pkg::FEAT_BITS-1:0]  info_waddr,
    input  logic [15:0]                    info_wdata,
    output logic                           busy,
    output logic [vbq_pkg::COORD_BITS-1:0] low_rdata,
    output logic [15:0]                    info_rdata
);
    logic [vbq_pkg::COORD_BITS-1:0] low_mem  [vbq_pkg::MAX_FEATURES];
    logic [15:0]                    info_mem [vbq_pkg::MAX_FEATURES];
    logic [vbq_pkg::COORD_BITS-1:0] low_q;
    logic [15:0]                    info_q;

    // Clearing pass: one entry per cycle over the whole table. Reset sweeps
    // both memories, begin sweeps only the lowest table.
    logic                          sweep_reg, sweep_next;
    logic                          sweep_info_reg, sweep_info_next;
    logic [vbq_pkg::FEAT_BITS-1:0] sweep_addr_reg, sweep_addr_next;

    always_comb begin
        sweep_next      = sweep_reg;
        sweep_info_next = sweep_info_reg;
        sweep_addr_next = sweep_addr_reg;
        if (clear_all) begin
            sweep_next      = 1'b1;
            sweep_info_next = 1'b0;
            sweep_addr_next = '0;
        end else if (sweep_reg) begin
            sweep_addr_next = sweep_addr_reg + 1'b1;
            // Table depth is a power of two: all ones is the last entry.
            if (&sweep_addr_reg) begin
                sweep_next      = 1'b0;
                sweep_info_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sweep_reg      <= 1'b1;
            sweep_info_reg <= 1'b1;
            sweep_addr_reg <= '0;
        end else begin
            sweep_reg      <= sweep_next;
            sweep_info_reg <= sweep_info_next;
            sweep_addr_reg <= sweep_addr_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (sweep_reg) low_mem[sweep_addr_reg] <= vbq_pkg::COORD_MAX;
        else if (low_we) low_mem[low_waddr] <= low_wdata;
        low_q <= low_mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (sweep_info_reg) info_mem[sweep_addr_reg] <= 16'd0;
        else if (info_we) info_mem[info_waddr] <= info_wdata;
        info_q <= info_mem[rd_addr];
    end

    assign busy       = sweep_reg;
    assign low_rdata  = low_q;
    assign info_rdata = info_q;
endmodule

@@ rtl/vertex_box_quantizer_top.sv @@
// Top level of the vertex box quantizer: config registers, sequencer,
// feature tables and shared divider. Depends on vbq_pkg, vbq_tables, vbq_divider.
//
//  channel   dir  handshake          contents
//  s_axis    in   s_tvalid/s_tready  tuser: op; tdata: east,north,up,feature_id,
//                                    info_index,info_word
//  m_axis    out  m_tvalid/m_tready  quant_east,quant_north,quant_up,height,info
//  cfg       in   cfg_we             cfg_index, cfg_data
//
// Load info writes the info table at accept and leaves the sequencer idle; measure
// runs read, read wait and measure steps. Emit runs read and read wait, then per
// axis setup, 16 divider steps, done and height steps, then output; a clamped axis
// goes from setup to its height step. Begin runs a clearing pass over the lowest
// table. Reset is synchronous active low and runs a clearing pass over both tables;
// s_tready stays low until it ends. One item is in work at a time; a finished word
// waits in the output register while the next item is accepted, and a second emit
// holds in its output step.
module vertex_box_quantizer_top (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // [1:0] op
    input  logic [1:0]   s_tuser,
    // [31:0] east, [63:32] north, [95:64] up, [127:96] feature_id,
    // [137:128] info_index, [153:138] info_word
    input  logic [159:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // [15:0] quant_east, [31:16] quant_north, [47:32] quant_up,
    // [63:48] height_above_base, [79:64] building_info
    output logic [79:0]  m_tdata,
    input  logic         cfg_we,
    input  logic [2:0]   cfg_index,
    input  logic [31:0]  cfg_data
);
    localparam logic [3:0] ST_IDLE = 4'd0, ST_RD = 4'd1, ST_RDW = 4'd2, ST_MEAS = 4'd3,
                           ST_DIVS = 4'd4, ST_DIVW = 4'd5, ST_HGT = 4'd6, ST_OUT = 4'd7;

    logic signed [31:0] box_lo_reg [3];
    logic signed [31:0] box_hi_reg [3];
    logic [10:0]        count_reg;
    logic               useid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 3; i++) begin
                box_lo_reg[i] <= '0;
                box_hi_reg[i] <= '0;
            end
            count_reg <= '0;
            useid_reg <= 1'b0;
        end else if (cfg_we) begin
            case (cfg_index)
                vbq_pkg::REG_MIN_E: box_lo_reg[0] <= cfg_data;
                vbq_pkg::REG_MIN_N: box_lo_reg[1] <= cfg_data;
                vbq_pkg::REG_MIN_U: box_lo_reg[2] <= cfg_data;
                vbq_pkg::REG_MAX_E: box_hi_reg[0] <= cfg_data;
                vbq_pkg::REG_MAX_N: box_hi_reg[1] <= cfg_data;
                vbq_pkg::REG_MAX_U: box_hi_reg[2] <= cfg_data;
                vbq_pkg::REG_COUNT: count_reg     <= cfg_data[10:0];
                vbq_pkg::REG_USEID: useid_reg     <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // Held item
    logic [3:0]         state_reg;
    logic [1:0]         op_reg;
    logic signed [31:0] coord_reg [3];
    logic [9:0]         feat_reg;
    logic [1:0]         axis_reg;
    logic [15:0]        q_reg [3];
    logic [31:0]        low_reg;
    logic [15:0]        info_reg;
    logic [15:0]        hgt_reg;
    logic               out_valid_reg;
    logic [79:0]        out_data_reg;

    // Feature pick from input word
    logic [31:0] fid_in;
    logic [10:0] ncount;
    logic [9:0]  feat_pick;
    assign fid_in = s_tdata[127:96];
    always_comb begin
        ncount = (count_reg == 11'd0) ? 11'd1 : count_reg;
        if (ncount > 11'd1024) ncount = 11'd1024;
        feat_pick = (useid_reg && ({21'd0, ncount} > fid_in)) ? fid_in[9:0] : 10'd0;
    end

    // Tables
    logic        clear_all, low_we, info_we, tbl_busy;
    logic [31:0] low_rdata;
    logic [15:0] info_rdata;
    logic [31:0] new_low;

    // Hold the input while an item is in work or a clearing pass runs.
    logic accept;
    assign s_tready = (state_reg == ST_IDLE) && !tbl_busy;
    assign accept = s_tvalid && s_tready;

    assign clear_all = accept && (s_tuser == vbq_pkg::OP_BEGIN);
    assign info_we   = accept && (s_tuser == vbq_pkg::OP_LOAD);
    assign new_low   = coord_reg[2];
    // Measure: one read-modify-write; the item interlock keeps accesses apart.
    assign low_we    = (state_reg == ST_MEAS) && ($signed(new_low) < $signed(low_reg));

    vbq_tables u_tables (
        .aclk(aclk), .aresetn(aresetn), .clear_all(clear_all),
        .rd_addr(accept ? feat_pick : feat_reg),
        .low_we(low_we), .low_waddr(feat_reg), .low_wdata(new_low),
        .info_we(info_we), .info_waddr(s_tdata[137:128]), .info_wdata(s_tdata[153:138]),
        .busy(tbl_busy), .low_rdata(low_rdata), .info_rdata(info_rdata)
    );

    // Box map operands for current axis
    logic signed [32:0] span, offs;
    logic               map_zero, map_full;
    vbq_pkg::div_req_t  dreq;
    vbq_pkg::div_rsp_t  drsp;
    always_comb begin
        span     = {box_hi_reg[axis_reg][31], box_hi_reg[axis_reg]}
                 - {box_lo_reg[axis_reg][31], box_lo_reg[axis_reg]};
        offs     = {coord_reg[axis_reg][31], coord_reg[axis_reg]}
                 - {box_lo_reg[axis_reg][31], box_lo_reg[axis_reg]};
        map_zero = (span <= 33'sd0) || (offs <= 33'sd0);
        map_full = !map_zero && (offs >= span);
        dreq.start = (state_reg == ST_DIVS) && !map_zero && !map_full;
        dreq.num   = ({17'd0, offs[32:0]} << 17) - ({17'd0, offs[32:0]} << 1)
                   + {17'd0, span[32:0]};
        dreq.den   = {span[32:0], 1'b0};
    end

    vbq_divider u_div (.aclk(aclk), .aresetn(aresetn), .req(dreq), .rsp(drsp));

    // Height: (dz+5)/10 by reciprocal 2^24/10; dz clamped first so product fits.
    logic signed [33:0] dz;
    logic [19:0]        dzc;
    logic [43:0]        hprod;
    logic [15:0]        hval;
    always_comb begin
        dz    = {{2{coord_reg[2][31]}}, coord_reg[2]} - {{2{low_reg[31]}}, low_reg};
        dzc   = (dz > 34'sd655350) ? 20'd655355 : dz[19:0] + 20'd5;
        hprod = {24'd0, dzc} * 44'd1677722;   // ~2^24/10
        hval  = (dz <= 34'sd0) ? 16'd0
              : (hprod[43:24] > 20'd65535) ? 16'd65535 : hprod[39:24];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            // Load a finished word, or drop the one the receiver took.
            if (state_reg == ST_OUT && (!out_valid_reg || m_tready))
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
            case (state_reg)
                ST_IDLE: if (accept && (s_tuser == vbq_pkg::OP_MEASURE ||
                                        s_tuser == vbq_pkg::OP_EMIT))
                    state_reg <= ST_RD;
                ST_RD:   state_reg <= ST_RDW;
                ST_RDW:  state_reg <= (op_reg == vbq_pkg::OP_MEASURE) ? ST_MEAS : ST_DIVS;
                ST_MEAS: state_reg <= ST_IDLE;
                ST_DIVS: state_reg <= (map_zero || map_full) ? ST_HGT : ST_DIVW;
                ST_DIVW: if (drsp.done) state_reg <= ST_HGT;
                ST_HGT: begin
                    if (axis_reg == 2'd2) state_reg <= ST_OUT;
                    else state_reg <= ST_DIVS;
                end
                ST_OUT:  if (!out_valid_reg || m_tready) state_reg <= ST_IDLE;
                default: state_reg <= ST_IDLE;
            endcase
        end
        if (accept) begin
            op_reg       <= s_tuser;
            coord_reg[0] <= s_tdata[31:0];
            coord_reg[1] <= s_tdata[63:32];
            coord_reg[2] <= s_tdata[95:64];
            feat_reg     <= feat_pick;
            axis_reg     <= 2'd0;
        end
        if (state_reg == ST_RDW) begin
            low_reg  <= low_rdata;
            info_reg <= info_rdata;
        end
        if (state_reg == ST_DIVS && (map_zero || map_full))
            q_reg[axis_reg] <= map_full ? 16'hFFFF : 16'd0;
        if (state_reg == ST_DIVW && drsp.done) q_reg[axis_reg] <= drsp.quo;
        if (state_reg == ST_HGT) begin
            if (axis_reg != 2'd2) axis_reg <= axis_reg + 2'd1;
            hgt_reg <= hval;
        end
        if (state_reg == ST_OUT && (!out_valid_reg || m_tready))
            out_data_reg <= {info_reg, hgt_reg, q_reg[2], q_reg[1], q_reg[0]};
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
endmodule
